@@ src/dss_pkg.sv @@
// ============================================================================
// dss_pkg
// Shared types, constants and the arctangent table for the directional
// sprite selector: transaction structs, pipeline payload and side codes.
// ============================================================================
package dss_pkg;

    // Field widths
    localparam int POS_W   = 32;
    localparam int DIFF_W  = POS_W + 1;
    localparam int VEC_W   = POS_W + 4;
    localparam int ANGLE_W = 16;
    localparam int CLIP_W  = 8;

    // Arctangent table depth and default iteration count
    localparam int ATAN_ENTRIES         = 24;
    localparam int CORDIC_STEPS_DEFAULT = 16;

    // Distance and sector limits
    localparam int NEAR_MAG_LIMIT = 32;
    localparam int NEAR_SQ_LIMIT  = 512;
    localparam logic signed [ANGLE_W-1:0] FRONT_LIMIT = 16'sd8192;
    localparam logic signed [ANGLE_W-1:0] BACK_LIMIT  = 16'sd24576;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'd16384;

    // View side codes
    typedef enum logic [1:0] {
        SIDE_FRONT = 2'd0,
        SIDE_BACK  = 2'd1,
        SIDE_LEFT  = 2'd2,
        SIDE_RIGHT = 2'd3
    } side_t;

    // Input transaction
    typedef struct packed {
        logic signed [POS_W-1:0]   object_x;
        logic signed [POS_W-1:0]   object_z;
        logic signed [ANGLE_W-1:0] object_yaw;
        logic signed [POS_W-1:0]   camera_x;
        logic signed [POS_W-1:0]   camera_z;
        logic                      clips_resolved;
        logic [CLIP_W-1:0]         front_clip;
        logic [CLIP_W-1:0]         back_clip;
        logic [CLIP_W-1:0]         left_clip;
        logic [CLIP_W-1:0]         right_clip;
    } item_t;

    // Result transaction
    typedef struct packed {
        logic [CLIP_W-1:0] chosen_clip;
        logic [1:0]        view_side;
        logic              selection_valid;
    } result_t;

    // CORDIC vector and angle accumulator
    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic [ANGLE_W-1:0]      z;
    } vec_t;

    // Side information carried alongside the rotation
    typedef struct packed {
        logic                      resolved;
        logic                      near;
        logic signed [ANGLE_W-1:0] yaw;
        logic [CLIP_W-1:0]         front_clip;
        logic [CLIP_W-1:0]         back_clip;
        logic [CLIP_W-1:0]         left_clip;
        logic [CLIP_W-1:0]         right_clip;
    } info_t;

    // atan(2^-idx) in binary angle units, 65536 per turn, rounded
    function automatic logic [ANGLE_W-1:0] atan_unit(input int idx);
        logic [ANGLE_W-1:0] r;
        case (idx)
            0:       r = 16'd8192;
            1:       r = 16'd4836;
            2:       r = 16'd2555;
            3:       r = 16'd1297;
            4:       r = 16'd651;
            5:       r = 16'd326;
            6:       r = 16'd163;
            7:       r = 16'd81;
            8:       r = 16'd41;
            9:       r = 16'd20;
            10:      r = 16'd10;
            11:      r = 16'd5;
            12:      r = 16'd3;
            13:      r = 16'd1;
            14:      r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

@@ src/dss_cordic_stage.sv @@
// ============================================================================
// dss_cordic_stage
// One registered CORDIC vectoring micro-rotation: drives y toward zero and
// accumulates the rotation angle, carrying side information alongside.
// ============================================================================
module dss_cordic_stage #(
    parameter int                          SHIFT = 0,
    parameter logic [dss_pkg::ANGLE_W-1:0] ANGLE = 16'd8192
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid_in,
    input  dss_pkg::vec_t   vec_in,
    input  dss_pkg::info_t  info_in,
    output logic            valid_out,
    output dss_pkg::vec_t   vec_out,
    output dss_pkg::info_t  info_out
);

    logic                            valid_reg;
    dss_pkg::vec_t                   vec_reg;
    dss_pkg::vec_t                   vec_next;
    dss_pkg::info_t                  info_reg;
    logic signed [dss_pkg::VEC_W-1:0] x_shift;
    logic signed [dss_pkg::VEC_W-1:0] y_shift;

    // Rotate toward the x axis; zero y counts as non-negative
    always_comb
    begin
        x_shift = vec_in.x >>> SHIFT;
        y_shift = vec_in.y >>> SHIFT;
        if (!vec_in.y[dss_pkg::VEC_W-1])
        begin
            vec_next.x = vec_in.x + y_shift;
            vec_next.y = vec_in.y - x_shift;
            vec_next.z = vec_in.z + ANGLE;
        end
        else
        begin
            vec_next.x = vec_in.x - y_shift;
            vec_next.y = vec_in.y + x_shift;
            vec_next.z = vec_in.z - ANGLE;
        end
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        vec_reg  <= vec_next;
        info_reg <= info_in;
    end

    assign valid_out = valid_reg;
    assign vec_out   = vec_reg;
    assign info_out  = info_reg;

endmodule

@@ src/directional_sprite_select_core.sv @@
// ============================================================================
// directional_sprite_select_core
// Picks the front, back, left or right sprite clip of an object from the
// bearing of the camera relative to the object's yaw.
// ============================================================================
// Usage:
//   Drive item and raise start for one cycle per transaction; a transaction
//   is accepted at every rising edge with start high and busy low. busy is
//   always low: the pipeline advances every cycle and takes one transaction
//   per clock, back to back.
//   Each transaction returns exactly one result: done is high for one cycle
//   with result valid in that cycle, in the order the transactions entered.
//   The pipeline is the unrolled CORDIC, one registered micro-rotation per
//   step (steps beyond 24 count as 24), plus a difference stage, a near
//   check and prerotation stage and a sector decode stage.
//   Throughput is one transaction per cycle.
//   The receiver cannot stall; results are shown once and never held.
//   Reset clears every valid bit in the pipeline; transactions in flight
//   are dropped and no result appears until new ones are accepted.
// ============================================================================
module directional_sprite_select_core #(
    parameter int CORDIC_STEPS = dss_pkg::CORDIC_STEPS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  dss_pkg::item_t   item,
    output logic             done,
    output dss_pkg::result_t result
);

    localparam int STEPS   = (CORDIC_STEPS < dss_pkg::ATAN_ENTRIES) ?
                             CORDIC_STEPS : dss_pkg::ATAN_ENTRIES;
    localparam int LATENCY = STEPS + 3;

    // Stage A: coordinate differences
    logic                              a_valid_reg;
    logic signed [dss_pkg::DIFF_W-1:0] a_dx_reg;
    logic signed [dss_pkg::DIFF_W-1:0] a_dz_reg;
    dss_pkg::info_t                    a_info_reg;
    dss_pkg::info_t                    a_info_next;

    // Stage B: near check and prerotation
    logic                              b_valid_reg;
    dss_pkg::vec_t                     b_vec_reg;
    dss_pkg::vec_t                     b_vec_next;
    dss_pkg::info_t                    b_info_reg;
    dss_pkg::info_t                    b_info_next;
    logic [dss_pkg::DIFF_W-1:0]        ax;
    logic [dss_pkg::DIFF_W-1:0]        az;
    logic [5:0]                        ax_lo;
    logic [5:0]                        az_lo;
    logic [12:0]                       dist_sq;
    logic signed [dss_pkg::VEC_W-1:0]  dx_ext;
    logic signed [dss_pkg::VEC_W-1:0]  dz_ext;

    // CORDIC chain
    logic                 c_valid [STEPS+1];
    dss_pkg::vec_t        c_vec   [STEPS+1];
    dss_pkg::info_t       c_info  [STEPS+1];

    // Output stage
    logic                               done_reg;
    dss_pkg::result_t                   result_reg;
    dss_pkg::result_t                   result_next;
    logic signed [dss_pkg::ANGLE_W-1:0] rel;
    dss_pkg::side_t                     side;

    assign busy = 1'b0;

    // Bundle the side information of an incoming transaction
    always_comb
    begin
        a_info_next.resolved   = item.clips_resolved;
        a_info_next.near       = 1'b0;
        a_info_next.yaw        = item.object_yaw;
        a_info_next.front_clip = item.front_clip;
        a_info_next.back_clip  = item.back_clip;
        a_info_next.left_clip  = item.left_clip;
        a_info_next.right_clip = item.right_clip;
    end

    // Stage A valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start && !busy;
        end
    end

    // Stage A payload: exact 33-bit differences
    always_ff @(posedge clk)
    begin
        a_dx_reg   <= {item.camera_x[dss_pkg::POS_W-1], item.camera_x}
                    - {item.object_x[dss_pkg::POS_W-1], item.object_x};
        a_dz_reg   <= {item.camera_z[dss_pkg::POS_W-1], item.camera_z}
                    - {item.object_z[dss_pkg::POS_W-1], item.object_z};
        a_info_reg <= a_info_next;
    end

    // Check for a camera on top of the object and prerotate the left half
    always_comb
    begin
        ax      = a_dx_reg[dss_pkg::DIFF_W-1] ? -a_dx_reg : a_dx_reg;
        az      = a_dz_reg[dss_pkg::DIFF_W-1] ? -a_dz_reg : a_dz_reg;
        ax_lo   = ax[5:0];
        az_lo   = az[5:0];
        dist_sq = 13'(ax_lo * ax_lo) + 13'(az_lo * az_lo);

        b_info_next      = a_info_reg;
        b_info_next.near = (ax <= dss_pkg::DIFF_W'(dss_pkg::NEAR_MAG_LIMIT))
                        && (az <= dss_pkg::DIFF_W'(dss_pkg::NEAR_MAG_LIMIT))
                        && (dist_sq <= 13'(dss_pkg::NEAR_SQ_LIMIT));

        dx_ext = {{(dss_pkg::VEC_W-dss_pkg::DIFF_W){a_dx_reg[dss_pkg::DIFF_W-1]}},
                  a_dx_reg};
        dz_ext = {{(dss_pkg::VEC_W-dss_pkg::DIFF_W){a_dz_reg[dss_pkg::DIFF_W-1]}},
                  a_dz_reg};

        if (!dx_ext[dss_pkg::VEC_W-1])
        begin
            b_vec_next.x = dx_ext;
            b_vec_next.y = dz_ext;
            b_vec_next.z = '0;
        end
        else if (!dz_ext[dss_pkg::VEC_W-1])
        begin
            b_vec_next.x = dz_ext;
            b_vec_next.y = -dx_ext;
            b_vec_next.z = dss_pkg::QUARTER_TURN;
        end
        else
        begin
            b_vec_next.x = -dz_ext;
            b_vec_next.y = dx_ext;
            b_vec_next.z = -dss_pkg::QUARTER_TURN;
        end
    end

    // Stage B valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    // Stage B payload
    always_ff @(posedge clk)
    begin
        b_vec_reg  <= b_vec_next;
        b_info_reg <= b_info_next;
    end

    // Unrolled CORDIC, one registered micro-rotation per step
    assign c_valid[0] = b_valid_reg;
    assign c_vec[0]   = b_vec_reg;
    assign c_info[0]  = b_info_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        dss_cordic_stage #(
            .SHIFT (i),
            .ANGLE (dss_pkg::atan_unit(i))
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (c_valid[i]),
            .vec_in    (c_vec[i]),
            .info_in   (c_info[i]),
            .valid_out (c_valid[i+1]),
            .vec_out   (c_vec[i+1]),
            .info_out  (c_info[i+1])
        );
    end

    // Subtract yaw, wrap to one turn and decode the sector
    always_comb
    begin
        rel = c_vec[STEPS].z - c_info[STEPS].yaw;
        if (c_info[STEPS].near)
        begin
            side = dss_pkg::SIDE_FRONT;
        end
        else if ((rel >= -dss_pkg::FRONT_LIMIT) && (rel <= dss_pkg::FRONT_LIMIT))
        begin
            side = dss_pkg::SIDE_FRONT;
        end
        else if ((rel >= dss_pkg::BACK_LIMIT) || (rel <= -dss_pkg::BACK_LIMIT))
        begin
            side = dss_pkg::SIDE_BACK;
        end
        else if (rel[dss_pkg::ANGLE_W-1])
        begin
            side = dss_pkg::SIDE_LEFT;
        end
        else
        begin
            side = dss_pkg::SIDE_RIGHT;
        end

        case (side)
            dss_pkg::SIDE_FRONT: result_next.chosen_clip = c_info[STEPS].front_clip;
            dss_pkg::SIDE_BACK:  result_next.chosen_clip = c_info[STEPS].back_clip;
            dss_pkg::SIDE_LEFT:  result_next.chosen_clip = c_info[STEPS].left_clip;
            default:             result_next.chosen_clip = c_info[STEPS].right_clip;
        endcase
        result_next.view_side       = side;
        result_next.selection_valid = 1'b1;

        // Drop everything for unresolved clips
        if (!c_info[STEPS].resolved)
        begin
            result_next = '0;
        end
    end

    // Output strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= c_valid[STEPS];
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every result traces back to an earlier accepted transaction
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching transaction");

    // Every accepted transaction later yields a result
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("transaction lost in pipeline");

    // An invalid selection carries zero clip and front side
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.selection_valid) |->
            (result.chosen_clip == '0 && result.view_side == dss_pkg::SIDE_FRONT))
        else $error("invalid selection carries payload");

endmodule

@@ tb/directional_sprite_select_checker.sv @@
// ============================================================================
// directional_sprite_select_checker
// Watches the transaction and result channels of the sprite selector,
// predicts the clip and view side of every accepted transaction, and
// compares each result with the oldest prediction still waiting.
// ============================================================================
module directional_sprite_select_checker #(
    parameter int CORDIC_STEPS = dss_pkg::CORDIC_STEPS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  dss_pkg::item_t   item,
    input  logic             done,
    input  dss_pkg::result_t result,
    output int               fail_count,
    output int               pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;
    localparam int ARCTAN_DEPTH = 24;

    // Arctangent of 2^-i in binary angle units, 65536 per turn
    localparam int ARCTAN_BAM [ARCTAN_DEPTH] = '{
        8192, 4836, 2555, 1297, 651, 326, 163, 81,
        41, 20, 10, 5, 3, 1, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    dss_pkg::result_t selections_due[$];
    int               mismatch_tally;

    // Bearing from object to camera by CORDIC vectoring, binary angle units
    function automatic int camera_bearing(input longint dx, input longint dz);
        longint vx;
        longint vy;
        longint sx;
        longint sy;
        longint held;
        int     acc;
        vx  = dx;
        vy  = dz;
        acc = 0;
        // Fold the left half-plane onto the right one by a quarter turn
        if (vx < 0)
        begin
            held = vx;
            if (vy >= 0)
            begin
                vx  = vy;
                vy  = -held;
                acc = int'(dss_pkg::QUARTER_TURN);
            end
            else
            begin
                vx  = -vy;
                vy  = held;
                acc = -int'(dss_pkg::QUARTER_TURN);
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < ARCTAN_DEPTH; i++)
        begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy >= 0)
            begin
                vx  = vx + sy;
                vy  = vy - sx;
                acc = acc + ARCTAN_BAM[i];
            end
            else
            begin
                vx  = vx - sy;
                vy  = vy + sx;
                acc = acc - ARCTAN_BAM[i];
            end
        end
        return acc;
    endfunction

    // Expected clip selection for one transaction
    function automatic dss_pkg::result_t predict_selection(input dss_pkg::item_t it);
        longint             dx;
        longint             dz;
        longint             ax;
        longint             az;
        int                 bearing_bam;
        logic [15:0]        rel_bits;
        logic signed [15:0] rel;
        int                 rel_mag;
        dss_pkg::side_t     side;
        dss_pkg::result_t   sel;
        sel = '0;
        if (it.clips_resolved !== 1'b1)
            return sel;
        dx = longint'($signed(it.camera_x)) - longint'($signed(it.object_x));
        dz = longint'($signed(it.camera_z)) - longint'($signed(it.object_z));
        ax = (dx < 0) ? -dx : dx;
        az = (dz < 0) ? -dz : dz;
        if (ax <= dss_pkg::NEAR_MAG_LIMIT && az <= dss_pkg::NEAR_MAG_LIMIT
                && ax * ax + az * az <= dss_pkg::NEAR_SQ_LIMIT)
        begin
            // Camera sits on the object: show the front
            side = dss_pkg::SIDE_FRONT;
        end
        else
        begin
            bearing_bam = camera_bearing(dx, dz);
            rel_bits    = bearing_bam[15:0] - it.object_yaw;
            rel         = $signed(rel_bits);
            rel_mag     = (rel < 0) ? -int'(rel) : int'(rel);
            if (rel_mag <= int'(dss_pkg::FRONT_LIMIT))
                side = dss_pkg::SIDE_FRONT;
            else if (rel_mag >= int'(dss_pkg::BACK_LIMIT))
                side = dss_pkg::SIDE_BACK;
            else if (rel < 0)
                side = dss_pkg::SIDE_LEFT;
            else
                side = dss_pkg::SIDE_RIGHT;
        end
        case (side)
            dss_pkg::SIDE_FRONT: sel.chosen_clip = it.front_clip;
            dss_pkg::SIDE_BACK:  sel.chosen_clip = it.back_clip;
            dss_pkg::SIDE_LEFT:  sel.chosen_clip = it.left_clip;
            default:             sel.chosen_clip = it.right_clip;
        endcase
        sel.view_side       = side;
        sel.selection_valid = 1'b1;
        return sel;
    endfunction

    // Count a failure; print only the first few
    task automatic flag_failure(input string what);
        mismatch_tally++;
        if (mismatch_tally <= REPORT_LIMIT)
            $display("[%0t] selector mismatch: %s", $realtime, what);
    endtask

    // Compare arriving results, then queue predictions for new transactions
    always @(posedge clk or negedge rst_n)
    begin
        dss_pkg::result_t want;
        if (!rst_n)
        begin
            selections_due.delete();
            mismatch_tally = 0;
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (selections_due.size() == 0)
                begin
                    flag_failure($sformatf("result with none pending: clip %0d side %0d valid %0b",
                        result.chosen_clip, result.view_side, result.selection_valid));
                end
                else
                begin
                    want = selections_due.pop_front();
                    if (result.chosen_clip !== want.chosen_clip)
                        flag_failure($sformatf("chosen_clip expected %0d got %0d",
                            want.chosen_clip, result.chosen_clip));
                    if (result.view_side !== want.view_side)
                        flag_failure($sformatf("view_side expected %0d got %0d",
                            want.view_side, result.view_side));
                    if (result.selection_valid !== want.selection_valid)
                        flag_failure($sformatf("selection_valid expected %0b got %0b",
                            want.selection_valid, result.selection_valid));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                selections_due.push_back(predict_selection(item));
            fail_count    <= mismatch_tally;
            pending_count <= selections_due.size();
        end
    end

endmodule

@@ tb/directional_sprite_select_core_tb.sv @@
// ============================================================================
// directional_sprite_select_core_tb
// Drives directed and random sprite transactions into the selector with
// random idle gaps, and leaves prediction and comparison to the checker.
// ============================================================================
module directional_sprite_select_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS        = dss_pkg::CORDIC_STEPS_DEFAULT;
    localparam int PIPE_DEPTH   = ((STEPS > dss_pkg::ATAN_ENTRIES) ?
                                   dss_pkg::ATAN_ENTRIES : STEPS) + 3;
    localparam int RANDOM_ITEMS = 1100;

    localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
    localparam logic signed [15:0] YAW_MAX = 16'sh7fff;
    localparam logic signed [15:0] YAW_MIN = 16'sh8000;

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    dss_pkg::item_t   item  = '0;
    logic             busy;
    logic             done;
    dss_pkg::result_t result;
    int               fail_count;
    int               pending_count;
    bit               no_idle_stretch = 1'b0;

    directional_sprite_select_core #(
        .CORDIC_STEPS (STEPS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    directional_sprite_select_checker #(
        .CORDIC_STEPS (STEPS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .done          (done),
        .result        (result),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Free-running clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Hard stop for a hung run
    initial
    begin
        #2_000_000;
        $display("directional_sprite_select_core_tb: errors");
        $finish;
    end

    function automatic dss_pkg::item_t make_item(
        input logic signed [31:0] ox,
        input logic signed [31:0] oz,
        input logic signed [15:0] yaw,
        input logic signed [31:0] cx,
        input logic signed [31:0] cz,
        input logic               resolved,
        input logic [7:0]         f,
        input logic [7:0]         b,
        input logic [7:0]         l,
        input logic [7:0]         r
    );
        dss_pkg::item_t it;
        it.object_x       = ox;
        it.object_z       = oz;
        it.object_yaw     = yaw;
        it.camera_x       = cx;
        it.camera_z       = cz;
        it.clips_resolved = resolved;
        it.front_clip     = f;
        it.back_clip      = b;
        it.left_clip      = l;
        it.right_clip     = r;
        return it;
    endfunction

    // Idle length before the next transaction: mostly short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle_stretch || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random transaction, weighted toward the near check and sector borders
    function automatic dss_pkg::item_t random_item();
        dss_pkg::item_t     it;
        int                 roll;
        int                 dir;
        logic signed [31:0] span;
        logic signed [31:0] dxv;
        logic signed [31:0] dzv;
        logic [15:0]        border;
        logic [15:0]        jitter;
        it.object_x       = $urandom;
        it.object_z       = $urandom;
        it.object_yaw     = 16'($urandom);
        it.camera_x       = $urandom;
        it.camera_z       = $urandom;
        it.clips_resolved = 1'b1;
        it.front_clip     = 8'($urandom);
        it.back_clip      = 8'($urandom);
        it.left_clip      = 8'($urandom);
        it.right_clip     = 8'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            // Unresolved clips
            it.clips_resolved = 1'b0;
        end
        else if (roll < 25)
        begin
            // Camera close to the object, around the near threshold
            it.object_x = $signed($urandom) >>> 1;
            it.object_z = $signed($urandom) >>> 1;
            it.camera_x = it.object_x + $signed(32'($urandom_range(0, 80))) - 32'sd40;
            it.camera_z = it.object_z + $signed(32'($urandom_range(0, 80))) - 32'sd40;
        end
        else if (roll < 50)
        begin
            // Axis or diagonal bearing with yaw placed near a sector border
            it.object_x = $signed($urandom) >>> 1;
            it.object_z = $signed($urandom) >>> 1;
            dir  = $urandom_range(0, 7);
            span = $urandom_range(40, 1 << 20);
            case (dir)
                0:
                begin
                    dxv = span;
                    dzv = 0;
                end
                1:
                begin
                    dxv = span;
                    dzv = span;
                end
                2:
                begin
                    dxv = 0;
                    dzv = span;
                end
                3:
                begin
                    dxv = -span;
                    dzv = span;
                end
                4:
                begin
                    dxv = -span;
                    dzv = 0;
                end
                5:
                begin
                    dxv = -span;
                    dzv = -span;
                end
                6:
                begin
                    dxv = 0;
                    dzv = -span;
                end
                default:
                begin
                    dxv = span;
                    dzv = -span;
                end
            endcase
            case ($urandom_range(0, 4))
                0:       border = 16'd8192;
                1:       border = -16'd8192;
                2:       border = 16'd24576;
                3:       border = -16'd24576;
                default: border = 16'h8000;
            endcase
            jitter        = 16'($urandom_range(0, 12)) - 16'd6;
            it.camera_x   = it.object_x + dxv;
            it.camera_z   = it.object_z + dzv;
            it.object_yaw = 16'(dir * 8192) - border + jitter;
        end
        else if (roll < 70)
        begin
            // Offset of random magnitude from the object
            it.object_x = $signed($urandom) >>> 1;
            it.object_z = $signed($urandom) >>> 1;
            it.camera_x = it.object_x + ($signed($urandom) >>> $urandom_range(0, 31));
            it.camera_z = it.object_z + ($signed($urandom) >>> $urandom_range(0, 31));
        end
        return it;
    endfunction

    // Present one transaction and hold it until accepted; start stays high
    task automatic push_item(input dss_pkg::item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    // Stimulus and verdict
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unresolved clips, with extreme positions and all-ones clips
        push_item(make_item(POS_MAX, POS_MIN, YAW_MAX, POS_MIN, POS_MAX, 1'b0,
                            8'hff, 8'hff, 8'hff, 8'hff));
        push_item(make_item(0, 0, 0, 0, 0, 1'b0, 8'h11, 8'h22, 8'h33, 8'h44));
        // Camera on the object and around the near threshold
        push_item(make_item(0, 0, 0, 0, 0, 1'b1, 8'ha5, 8'h01, 8'h02, 8'h03));
        push_item(make_item(100, -100, 16'sd20000, 116, -84, 1'b1, 8'h00, 8'hff, 8'h0f, 8'hf0));
        push_item(make_item(100, 100, 0, 84, 116, 1'b1, 8'h10, 8'h20, 8'h30, 8'h40));
        push_item(make_item(0, 0, 0, 16, 17, 1'b1, 8'h10, 8'h20, 8'h30, 8'h40));
        push_item(make_item(0, 0, 0, 32, 0, 1'b1, 8'h10, 8'h20, 8'h30, 8'h40));
        push_item(make_item(0, 0, 0, -33, 0, 1'b1, 8'h10, 8'h20, 8'h30, 8'h40));
        // Largest differences in each direction
        push_item(make_item(POS_MIN, 0, 0, POS_MAX, 0, 1'b1, 8'h01, 8'h02, 8'h03, 8'h04));
        push_item(make_item(POS_MAX, 0, 0, POS_MIN, 0, 1'b1, 8'h01, 8'h02, 8'h03, 8'h04));
        push_item(make_item(POS_MAX, POS_MAX, 0, POS_MIN, POS_MIN, 1'b1,
                            8'h01, 8'h02, 8'h03, 8'h04));
        push_item(make_item(POS_MIN, POS_MIN, 0, POS_MAX, POS_MAX, 1'b1,
                            8'h01, 8'h02, 8'h03, 8'h04));
        push_item(make_item(0, POS_MIN, 0, 0, POS_MAX, 1'b1, 8'h01, 8'h02, 8'h03, 8'h04));
        push_item(make_item(0, POS_MAX, 0, 0, POS_MIN, 1'b1, 8'h01, 8'h02, 8'h03, 8'h04));
        // Left half-plane with positive and negative z
        push_item(make_item(0, 0, 0, -1000, 1000, 1'b1, 8'h05, 8'h06, 8'h07, 8'h08));
        push_item(make_item(0, 0, 0, -1000, -1000, 1'b1, 8'h05, 8'h06, 8'h07, 8'h08));
        // Yaw extremes and values on the sector borders
        push_item(make_item(0, 0, YAW_MIN, 65536, 0, 1'b1, 8'h09, 8'h0a, 8'h0b, 8'h0c));
        push_item(make_item(0, 0, YAW_MAX, 65536, 0, 1'b1, 8'h09, 8'h0a, 8'h0b, 8'h0c));
        push_item(make_item(0, 0, 16'sd8192, 65536, 0, 1'b1, 8'h09, 8'h0a, 8'h0b, 8'h0c));
        push_item(make_item(0, 0, -16'sd8192, 65536, 0, 1'b1, 8'h09, 8'h0a, 8'h0b, 8'h0c));
        push_item(make_item(0, 0, 16'sd24576, 65536, 0, 1'b1, 8'h09, 8'h0a, 8'h0b, 8'h0c));
        push_item(make_item(0, 0, -16'sd24576, 65536, 0, 1'b1, 8'h09, 8'h0a, 8'h0b, 8'h0c));
        // Right and left sides
        push_item(make_item(0, 0, 0, 0, 65536, 1'b1, 8'h00, 8'h00, 8'h00, 8'hff));
        push_item(make_item(0, 0, 0, 0, -65536, 1'b1, 8'h00, 8'h00, 8'hff, 8'h00));

        // Random traffic, with occasional stretches free of idle cycles
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
                no_idle_stretch = ($urandom_range(0, 99) < 25);
            push_item(random_item());
        end
        start <= 1'b0;

        // Drain the pipeline, then watch for stray results
        do @(posedge clk); while (pending_count != 0);
        repeat (2 * PIPE_DEPTH) @(posedge clk);
        if (fail_count == 0)
            $display("directional_sprite_select_core_tb: clean");
        else
            $display("directional_sprite_select_core_tb: errors");
        $finish;
    end

endmodule
